/* hw/rtl/melg_pkg.sv */
package melg_pkg;

	// Default sizes of the generator
	localparam int WORD_BITS_DEF = 64;
	localparam int NUM_WORDS_DEF = 312;

	// Fixed field widths
	localparam int INDEX_BITS    = 9;
	localparam int LAG_BITS      = 9;
	localparam int SHIFT_BITS    = 6;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_ADDR_BITS = 3;

	// Register reset values
	localparam int                      LAG_RESET    = 81;
	localparam logic [SHIFT_BITS-1:0]   SPLIT_RESET  = 6'd19;
	localparam logic [SHIFT_BITS-1:0]   LSHIFT_RESET = 6'd23;
	localparam logic [SHIFT_BITS-1:0]   RSHIFT_RESET = 6'd33;
	localparam logic [CFG_DATA_BITS-1:0] TWIST_RESET = 64'd0;

	// Configuration register indexes
	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_LAG    = 3'd0,
		REG_SPLIT  = 3'd1,
		REG_LSHIFT = 3'd2,
		REG_RSHIFT = 3'd3,
		REG_TWIST  = 3'd4
	} melg_cfg_reg_t;

	// Request action codes
	localparam logic ACT_STEP = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MIX,
		ST_WRITE
	} melg_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // write one state word, if its index is in range
		logic start;   // read w[i] and w[i+1]
		logic fetch;   // form x, read middle tap
		logic mix;     // compute new v
		logic commit;  // write back, advance, present result
	} melg_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic rem_busy;  // lag reduction still running
		logic out_free;  // output register can take a word
	} melg_sts_t;

endpackage

/* hw/rtl/melg_ifc.sv */
// Request channel: one step or one state-word load
interface melg_in_if #(
	parameter int WORD_BITS = melg_pkg::WORD_BITS_DEF
);
	import melg_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [INDEX_BITS-1:0] word_index;
	logic [WORD_BITS-1:0]  word_value;

	modport source (output valid, action, word_index, word_value, input ready);
	modport sink   (input valid, action, word_index, word_value, output ready);
endinterface

// Result channel: one generated word
interface melg_out_if #(
	parameter int WORD_BITS = melg_pkg::WORD_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] out_word;

	modport source (output valid, out_word, input ready);
	modport sink   (input valid, out_word, output ready);
endinterface

/* hw/rtl/melg_recurrence_step.sv */
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   action, word_index, word_value
// out_ch   out  valid/ready   out_word
// cfg      in   cfg_write     cfg_index, cfg_data (no read-back)
//
// A load request is written when accepted, leaving the request side open. A
// step request runs two ring reads, the middle-tap read, the v update and the
// write-back in sequence through the single controller, and no request is
// accepted until the step has written back and presented its result.
// A write to the lag register starts a modulo reduction, quotient then
// remainder, during which no request is accepted.
// Reset clears v, the pointer, the registers and the controller; ring words
// hold nothing until loaded. A stalled result sits in the output register
// while the next request is accepted; a step then waits at write-back.
module melg_recurrence_step #(
	parameter int WORD_BITS = melg_pkg::WORD_BITS_DEF,
	parameter int NUM_WORDS = melg_pkg::NUM_WORDS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [melg_pkg::CFG_ADDR_BITS-1:0] cfg_index,
	input  logic [melg_pkg::CFG_DATA_BITS-1:0] cfg_data,
	melg_in_if.sink                            in_ch,
	melg_out_if.source                         out_ch
);
	import melg_pkg::*;

	melg_cmd_t cmd;
	melg_sts_t sts;

	melg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_action (in_ch.action),
		.in_ready  (in_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	melg_dpath #(
		.WORD_BITS (WORD_BITS),
		.NUM_WORDS (NUM_WORDS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.word_index (in_ch.word_index),
		.word_value (in_ch.word_value),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_word   (out_ch.out_word)
	);

	// a step keeps the request side closed on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && (in_ch.action == ACT_STEP) |=> !in_ch.ready)
		else $error("request accepted during a step");

	// no request while the lag reduction runs
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !sts.rem_busy)
		else $error("request side open during lag reduction");

	// write-back always presents a result
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_ch.valid)
		else $error("result lost at write-back");

	// a lag write closes the request side
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && (cfg_index == REG_LAG) |=> !in_ch.ready)
		else $error("request side open after lag write");

endmodule

/* hw/rtl/melg_lag_rem.sv */
// Reduces the lag register modulo the ring size: a reciprocal multiply gives
// the quotient, a multiply-subtract on the next cycle gives the remainder
module melg_lag_rem #(
	parameter int RING = melg_pkg::NUM_WORDS_DEF - 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [melg_pkg::LAG_BITS-1:0] lag_in,
	output logic                          busy,
	output logic [$clog2(RING)-1:0]       lag_mod
);
	import melg_pkg::*;

	localparam int AW = $clog2(RING);
	localparam int RW = $clog2(RING + 1);
	// shift of LAG_BITS + ceil(log2 RING) makes the quotient exact for any lag
	localparam int SH = LAG_BITS + AW;
	localparam int MW = LAG_BITS + 2;
	localparam int PW = LAG_BITS + MW;
	localparam int QW = LAG_BITS + RW;
	localparam logic [MW-1:0]       RECIP     = MW'(((1 << SH) + RING - 1) / RING);
	localparam logic [RW-1:0]       RING_C    = RW'(RING);
	localparam logic [LAG_BITS-1:0] LAG_INIT  = LAG_BITS'(LAG_RESET);
	localparam logic [LAG_BITS-1:0] QUO_RESET = LAG_BITS'(LAG_RESET / RING);
	localparam logic [LAG_BITS-1:0] REM_RESET = LAG_BITS'(LAG_RESET % RING);

	logic [LAG_BITS-1:0] lag_q, quo_q, rem_q;
	logic                quo_pend_q, rem_pend_q;
	logic [PW-1:0]       prod;
	logic [QW-1:0]       back;

	assign busy    = quo_pend_q || rem_pend_q;
	assign lag_mod = AW'(rem_q);

	// quotient estimate and the multiple of the ring size it stands for
	assign prod = PW'(lag_q) * PW'(RECIP);
	assign back = QW'(quo_q) * QW'(RING_C);

	// after a write the quotient is registered first, then the remainder from it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_q      <= LAG_INIT;
			quo_q      <= QUO_RESET;
			rem_q      <= REM_RESET;
			quo_pend_q <= 1'b0;
			rem_pend_q <= 1'b0;
		end else if (load) begin
			lag_q      <= lag_in;
			quo_pend_q <= 1'b1;
			rem_pend_q <= 1'b0;
		end else begin
			if (quo_pend_q) begin
				quo_q <= LAG_BITS'(prod >> SH);
			end
			if (rem_pend_q) begin
				rem_q <= lag_q - LAG_BITS'(back);
			end
			quo_pend_q <= 1'b0;
			rem_pend_q <= quo_pend_q;
		end
	end

endmodule

/* hw/rtl/melg_ctrl.sv */
// Sequencer for load and step requests
module melg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_action,
	output logic                 in_ready,
	output melg_pkg::melg_cmd_t  cmd,
	input  melg_pkg::melg_sts_t  sts
);
	import melg_pkg::*;

	melg_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !sts.rem_busy;
				if (in_valid && in_ready) begin
					if (in_action == ACT_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_MIX;
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				// hold until the output register frees up
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/melg_dpath.sv */
// Word ring, v, pointer, registers and recurrence arithmetic
module melg_dpath #(
	parameter int WORD_BITS = melg_pkg::WORD_BITS_DEF,
	parameter int NUM_WORDS = melg_pkg::NUM_WORDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [melg_pkg::CFG_ADDR_BITS-1:0]  cfg_index,
	input  logic [melg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic [melg_pkg::INDEX_BITS-1:0]     word_index,
	input  logic [WORD_BITS-1:0]                word_value,
	input  melg_pkg::melg_cmd_t                 cmd,
	output melg_pkg::melg_sts_t                 sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [WORD_BITS-1:0]                out_word
);
	import melg_pkg::*;

	localparam int RING = NUM_WORDS - 1;
	localparam int AW   = $clog2(RING);

	// configuration
	logic [SHIFT_BITS-1:0] split_q, lshift_q, rshift_q;
	logic [WORD_BITS-1:0]  twist_q;
	logic                  lag_wr;
	logic [AW-1:0]         lag_mod;
	logic                  rem_busy;

	// state
	logic [WORD_BITS-1:0]  ring_mem [RING];
	logic [WORD_BITS-1:0]  v_q;
	logic [AW-1:0]         ptr_q;

	// step work registers
	logic [WORD_BITS-1:0]  rd_a_q, rd_b_q, x_q, vn_q, out_q;
	logic                  outv_q;

	logic [WORD_BITS-1:0]  hi_mask, lo_mask, xa, vn, nw;
	logic [AW-1:0]         nxt_ptr, tap_ptr, rd_a_addr, mem_waddr;
	logic [AW:0]           tap_sum;
	logic                  load_ring, load_v, mem_we;
	logic [WORD_BITS-1:0]  mem_wdata;

	assign lag_wr = cfg_write && (cfg_index == REG_LAG);

	melg_lag_rem #(
		.RING (RING)
	) u_lag_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (lag_wr),
		.lag_in  (cfg_data[LAG_BITS-1:0]),
		.busy    (rem_busy),
		.lag_mod (lag_mod)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q  <= SPLIT_RESET;
			lshift_q <= LSHIFT_RESET;
			rshift_q <= RSHIFT_RESET;
			twist_q  <= TWIST_RESET[WORD_BITS-1:0];
		end else if (cfg_write) begin
			case (melg_cfg_reg_t'(cfg_index))
				REG_SPLIT:  split_q  <= cfg_data[SHIFT_BITS-1:0];
				REG_LSHIFT: lshift_q <= cfg_data[SHIFT_BITS-1:0];
				REG_RSHIFT: rshift_q <= cfg_data[SHIFT_BITS-1:0];
				REG_TWIST:  twist_q  <= cfg_data[WORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// split masks: a split of WORD_BITS or more takes all of w[i+1]
	assign hi_mask = {WORD_BITS{1'b1}} << split_q;
	assign lo_mask = ~hi_mask;

	// ring addresses
	assign nxt_ptr = (ptr_q == AW'(RING - 1)) ? '0 : ptr_q + 1'b1;
	assign tap_sum = {1'b0, ptr_q} + {1'b0, lag_mod};
	assign tap_ptr = (tap_sum >= (AW+1)'(RING)) ? AW'(tap_sum - (AW+1)'(RING))
	                                            : AW'(tap_sum);
	assign rd_a_addr = cmd.fetch ? tap_ptr : ptr_q;

	// recurrence
	assign xa = (x_q >> 1) ^ (x_q[0] ? twist_q : '0);
	assign vn = xa ^ rd_a_q ^ v_q ^ (v_q << lshift_q);
	assign nw = x_q ^ vn_q ^ (vn_q >> rshift_q);

	// load decode; word zero keeps only its upper part
	assign load_ring = (32'(word_index) < RING);
	assign load_v    = (32'(word_index) == RING);
	assign mem_we    = (cmd.load && load_ring) || cmd.commit;
	assign mem_waddr = cmd.commit ? ptr_q : AW'(word_index);
	assign mem_wdata = cmd.commit ? nw :
	                   (word_index == '0) ? (word_value & hi_mask) : word_value;

	// ring memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.start || cmd.fetch) begin
			rd_a_q <= ring_mem[rd_a_addr];
		end
		if (cmd.start) begin
			rd_b_q <= ring_mem[nxt_ptr];
		end
	end

	// step work registers
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			x_q <= (rd_a_q & hi_mask) | (rd_b_q & lo_mask);
		end
		if (cmd.mix) begin
			vn_q <= vn;
		end
		if (cmd.commit) begin
			out_q <= nw;
		end
	end

	// v and ring pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			ptr_q <= '0;
		end else if (cmd.load) begin
			if (load_v) begin
				v_q <= word_value;
			end
			ptr_q <= '0;
		end else if (cmd.commit) begin
			v_q   <= vn_q;
			ptr_q <= nxt_ptr;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outv_q <= 1'b0;
		end else if (cmd.commit) begin
			outv_q <= 1'b1;
		end else if (out_ready) begin
			outv_q <= 1'b0;
		end
	end

	assign out_valid    = outv_q;
	assign out_word     = out_q;
	assign sts.rem_busy = rem_busy;
	assign sts.out_free = !outv_q || out_ready;

endmodule

/* tb/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import melg_pkg::*;

	localparam int W           = WORD_BITS_DEF;
	localparam int RING_WORDS  = NUM_WORDS_DEF - 1;
	localparam int IDLE_PCT    = 17;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 16;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_write;
	logic [CFG_ADDR_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	melg_in_if  #(.WORD_BITS(W)) req_bus ();
	melg_out_if #(.WORD_BITS(W)) res_bus ();

	melg_recurrence_step #(
		.WORD_BITS(W),
		.NUM_WORDS(NUM_WORDS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(req_bus),
		.out_ch(res_bus)
	);

	// Generator state as predicted
	logic [W-1:0]            ring_words [RING_WORDS];
	logic [W-1:0]            v_word;
	int unsigned             ring_ptr;
	logic [LAG_BITS-1:0]     lag_reg;
	logic [SHIFT_BITS-1:0]   split_reg;
	logic [SHIFT_BITS-1:0]   lshift_reg;
	logic [SHIFT_BITS-1:0]   rshift_reg;
	logic [CFG_DATA_BITS-1:0] twist_reg;

	logic [W-1:0] pending_words [$];
	int           failures    = 0;
	int           cycle_count = 0;
	bit           steady      = 1'b0;

	// Clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** melg_recurrence_step: FAILED **");
			$finish;
		end
	end

	// Result side back-pressure
	always @(posedge clk) begin
		res_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// Result checker
	always @(posedge clk) begin
		logic [W-1:0] want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_words.size() == 0) begin
				$error("out_word: expected none, actual %h", res_bus.out_word);
				failures++;
			end else begin
				want = pending_words.pop_front();
				if (res_bus.out_word !== want) begin
					$error("out_word: expected %h, actual %h", want, res_bus.out_word);
					failures++;
				end
			end
		end
	end

	// Predicted effect of one accepted request
	task automatic generator_update(input logic act, input logic [INDEX_BITS-1:0] idx,
			input logic [W-1:0] val);
		logic [W-1:0] lo_mask, hi_mask, x, xa, v_next, new_word, v_shl, v_shr;
		int unsigned  i, i1, im;
		lo_mask = (split_reg >= W) ? '1 : ((W'(1) << split_reg) - W'(1));
		hi_mask = ~lo_mask;
		if (act == ACT_LOAD) begin
			if (idx == RING_WORDS)
				v_word = val;
			else if (idx < RING_WORDS)
				ring_words[idx] = (idx == 0) ? (val & hi_mask) : val;
			ring_ptr = 0;
		end else begin
			i  = ring_ptr;
			i1 = (i + 1) % RING_WORDS;
			im = (i + (lag_reg % RING_WORDS)) % RING_WORDS;
			x  = (ring_words[i] & hi_mask) | (ring_words[i1] & lo_mask);
			xa = x >> 1;
			if (x[0])
				xa ^= twist_reg[W-1:0];
			v_shl    = (lshift_reg >= W) ? '0 : (v_word << lshift_reg);
			v_next   = xa ^ ring_words[im] ^ v_word ^ v_shl;
			v_shr    = (rshift_reg >= W) ? '0 : (v_next >> rshift_reg);
			new_word = x ^ v_next ^ v_shr;
			ring_words[i] = new_word;
			v_word   = v_next;
			ring_ptr = i1;
			pending_words.push_back(new_word);
		end
	endtask

	// Drive one request, with random idle cycles ahead of it
	task automatic send_request(input logic act, input logic [INDEX_BITS-1:0] idx,
			input logic [W-1:0] val);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			req_bus.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < IDLE_PCT);
		end
		req_bus.valid      <= 1'b1;
		req_bus.action     <= act;
		req_bus.word_index <= idx;
		req_bus.word_value <= val;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		generator_update(act, idx, val);
	endtask

	function automatic logic [W-1:0] rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// A step carries random don't-care payload
	task automatic step_once();
		send_request(ACT_STEP, INDEX_BITS'($urandom), {$urandom, $urandom});
	endtask

	task automatic load_word(input int idx, input logic [W-1:0] val);
		send_request(ACT_LOAD, INDEX_BITS'(idx), val);
	endtask

	// Hold off requests until every predicted word has come out
	task automatic drain_results();
		req_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input melg_cfg_reg_t sel, input logic [CFG_DATA_BITS-1:0] data);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= data;
		case (sel)
			REG_LAG:    lag_reg    = data[LAG_BITS-1:0];
			REG_SPLIT:  split_reg  = data[SHIFT_BITS-1:0];
			REG_LSHIFT: lshift_reg = data[SHIFT_BITS-1:0];
			REG_RSHIFT: rshift_reg = data[SHIFT_BITS-1:0];
			REG_TWIST:  twist_reg  = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_config(input int lag, input int split, input int lsh, input int rsh,
			input logic [CFG_DATA_BITS-1:0] twist);
		write_reg(REG_LAG, CFG_DATA_BITS'(lag));
		write_reg(REG_SPLIT, CFG_DATA_BITS'(split));
		write_reg(REG_LSHIFT, CFG_DATA_BITS'(lsh));
		write_reg(REG_RSHIFT, CFG_DATA_BITS'(rsh));
		write_reg(REG_TWIST, twist);
	endtask

	// Every ring word and v get a value before any step reads them
	task automatic test_fill_ring();
		for (int k = 0; k < RING_WORDS; k++)
			load_word(k, rand_word());
		load_word(RING_WORDS, {$urandom, $urandom});
	endtask

	// Loads: word zero masking, v, out-of-range indexes, no result on load
	task automatic test_load_cases();
		load_word(0, '1);
		load_word(511, '1);
		load_word(312, 64'h5555_5555_5555_5555);
		load_word(RING_WORDS, '1);
		step_once();
		step_once();
		load_word(1, '0);
		load_word(2, '1);
		step_once();
		step_once();
		step_once();
	endtask

	// Split and shift extremes, lag at and beyond the ring size
	task automatic test_config_corners();
		write_reg(REG_TWIST, {$urandom, $urandom} | 64'h1);
		write_reg(REG_SPLIT, 0);
		step_once();
		step_once();
		write_reg(REG_SPLIT, 63);
		write_reg(REG_LSHIFT, 63);
		write_reg(REG_RSHIFT, 63);
		step_once();
		step_once();
		write_reg(REG_LSHIFT, 0);
		write_reg(REG_RSHIFT, 0);
		write_reg(REG_LAG, CFG_DATA_BITS'(RING_WORDS));
		step_once();
		step_once();
		write_reg(REG_LAG, 511);
		step_once();
		step_once();
		write_reg(REG_LAG, 0);
		write_reg(REG_TWIST, '1);
		step_once();
		step_once();
	endtask

	// Sender holds back mid-stream until all results are in
	task automatic test_pause_for_results();
		repeat (6) step_once();
		drain_results();
		repeat (6) step_once();
	endtask

	// Random mix; a zero load share lets the pointer wrap the ring
	task automatic random_phase(input int count, input int load_pct, input int steady_count);
		int idx;
		for (int n = 0; n < count; n++) begin
			steady = (n < steady_count);
			if ($urandom_range(99) < load_pct) begin
				idx = ($urandom_range(9) == 0) ? $urandom_range(511, 312)
				                               : $urandom_range(RING_WORDS, 0);
				load_word(idx, rand_word());
			end else begin
				step_once();
			end
		end
		steady = 1'b0;
	endtask

	task automatic test_random_default();
		set_config(LAG_RESET, int'(SPLIT_RESET), int'(LSHIFT_RESET), int'(RSHIFT_RESET),
			{$urandom, $urandom});
		random_phase(340, 12, 150);
	endtask

	task automatic test_random_wide();
		set_config(310, 63, 0, 63, '1);
		random_phase(340, 0, 0);
	endtask

	task automatic test_random_narrow();
		set_config(1, 0, 63, 0, {$urandom, $urandom});
		random_phase(330, 15, 0);
	endtask

	task automatic test_random_mixed();
		set_config($urandom_range(511, 0), $urandom_range(63, 0), $urandom_range(63, 0),
			$urandom_range(63, 0), {$urandom, $urandom});
		random_phase(330, 25, 0);
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_write         <= 1'b0;
		cfg_index         <= REG_LAG;
		cfg_data          <= '0;
		req_bus.valid     <= 1'b0;
		req_bus.action    <= ACT_STEP;
		req_bus.word_index <= '0;
		req_bus.word_value <= '0;

		// Reset values of the predicted state
		foreach (ring_words[k])
			ring_words[k] = '0;
		v_word     = '0;
		ring_ptr   = 0;
		lag_reg    = LAG_BITS'(LAG_RESET);
		split_reg  = SPLIT_RESET;
		lshift_reg = LSHIFT_RESET;
		rshift_reg = RSHIFT_RESET;
		twist_reg  = TWIST_RESET;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_ring();
		test_load_cases();
		test_config_corners();
		test_pause_for_results();
		test_random_default();
		test_random_wide();
		test_random_narrow();
		test_random_mixed();

		drain_results();
		repeat (40) @(posedge clk);
		if (failures == 0)
			$display("** melg_recurrence_step: PASSED **");
		else
			$display("** melg_recurrence_step: FAILED **");
		$finish;
	end
endmodule
